// ===== sv/ds2i_pkg.sv =====
package ds2i_pkg;

   // Character codes
   localparam logic [7:0] MinusCode = 8'h2D;
   localparam logic [7:0] ZeroCode  = 8'h30;
   localparam logic [7:0] NineCode  = 8'h39;

   localparam int AccWidth = 64;

   // Largest negative magnitude accepted (2^63)
   localparam logic [AccWidth-1:0] NegLimit = {1'b1, {(AccWidth-1){1'b0}}};

   // Parse state carried from one character to the next
   typedef struct packed {
      logic [AccWidth-1:0] acc;
      logic                neg;
      logic                failed;
      logic                at_start;
      logic                digit_seen;
   } parse_state_type;

   localparam parse_state_type StateReset = '{
      acc:        '0,
      neg:        1'b0,
      failed:     1'b0,
      at_start:   1'b1,
      digit_seen: 1'b0
   };

   // Result of one finished string
   typedef struct packed {
      logic                is_integer;
      logic [AccWidth-1:0] value;
   } parse_result_type;

endpackage

// ===== sv/ds2i_step.sv =====
module ds2i_step (
   input  ds2i_pkg::parse_state_type  state,
   input  logic [7:0]                 char_code,
   input  logic                       has_char,
   input  logic                       last,
   output ds2i_pkg::parse_state_type  state_next,
   output ds2i_pkg::parse_result_type result
);

   ds2i_pkg::parse_state_type after;
   logic                      is_digit;
   logic [3:0]                digit;
   logic [ds2i_pkg::AccWidth+3:0] times_ten;
   logic [ds2i_pkg::AccWidth+3:0] sum;
   logic                      ok;

   // Multiply by ten as two shifts, then add the digit; carry bits flag overflow
   assign is_digit  = (char_code >= ds2i_pkg::ZeroCode) && (char_code <= ds2i_pkg::NineCode);
   assign digit     = 4'(char_code - ds2i_pkg::ZeroCode);
   assign times_ten = {1'b0, state.acc, 3'b000} + {3'b000, state.acc, 1'b0};
   assign sum       = times_ten + (ds2i_pkg::AccWidth+4)'(digit);

   // Fold one character into the parse state
   always_comb begin
      after          = state;
      after.at_start = state.at_start && !has_char;
      if (has_char && !state.failed) begin
         if (state.at_start && char_code == ds2i_pkg::MinusCode) begin
            after.neg = 1'b1;
         end else if (!is_digit) begin
            after.failed = 1'b1;
         end else if (sum[ds2i_pkg::AccWidth+3:ds2i_pkg::AccWidth] != 4'd0) begin
            after.failed = 1'b1;
         end else begin
            after.acc        = sum[ds2i_pkg::AccWidth-1:0];
            after.digit_seen = 1'b1;
         end
      end
   end

   // Range check against the signed 64-bit limits and form the value
   always_comb begin
      ok = !after.failed && after.digit_seen &&
           (after.neg ? (after.acc <= ds2i_pkg::NegLimit) : !after.acc[ds2i_pkg::AccWidth-1]);
      result.is_integer = ok;
      if (!ok) begin
         result.value = '0;
      end else if (after.neg) begin
         result.value = '0 - after.acc;
      end else begin
         result.value = after.acc;
      end
   end

   // Start over after the end of a string
   assign state_next = last ? ds2i_pkg::StateReset : after;

endmodule

// ===== sv/decimal_string_to_int64.sv =====
// Channel   Direction  Ports                                        Transaction
// req       in         req_char_code, req_has_char, req_last        one character
// rsp       out        rsp_is_integer, rsp_int_value                one parsed string
//
// One character per cycle unless a last character waits: an input register, then
// one step (multiply by ten, add digit, carry check, range check) into the parse
// state and result register.
// Reset is synchronous; it empties both stages and clears the parse state.
// A last character waits in the input register while a result is held unaccepted;
// other characters keep flowing.
module decimal_string_to_int64 (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_code,
   input  logic               req_has_char,
   input  logic               req_last,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_is_integer,
   output logic signed [63:0] rsp_int_value
);

   logic                       s1_valid_ff, s1_valid_in;
   logic [7:0]                 s1_char_ff;
   logic                       s1_has_ff;
   logic                       s1_last_ff;
   logic                       s1_fire;
   logic                       rsp_free;
   ds2i_pkg::parse_state_type  state_ff, state_in, state_step;
   ds2i_pkg::parse_result_type result_ff, result_step;
   logic                       rsp_valid_ff, rsp_valid_in;

   // Advance stage one unless a finished string has nowhere to go
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && (!s1_last_ff || rsp_free);
   assign req_ready = !s1_valid_ff || s1_fire;

   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !s1_fire);

   ds2i_step u_step (
      .state      (state_ff),
      .char_code  (s1_char_ff),
      .has_char   (s1_has_ff),
      .last       (s1_last_ff),
      .state_next (state_step),
      .result     (result_step)
   );

   assign state_in     = s1_fire ? state_step : state_ff;
   assign rsp_valid_in = (s1_fire && s1_last_ff) || (rsp_valid_ff && !rsp_ready);

   // Control and parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ds2i_pkg::StateReset;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Capture the input transaction
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_char_ff <= req_char_code;
         s1_has_ff  <= req_has_char;
         s1_last_ff <= req_last;
      end
   end

   // Load the result register at the end of a string
   always_ff @(posedge clock) begin
      if (s1_fire && s1_last_ff) begin
         result_ff <= result_step;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_integer = result_ff.is_integer;
   assign rsp_int_value  = $signed(result_ff.value);

   // A failed string reports zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_integer |-> rsp_int_value == 64'sd0)
      else $error("failed string with nonzero value");

   // A blocked last character holds in stage one
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff && rsp_valid_ff && !rsp_ready |=>
         s1_valid_ff && s1_last_ff && $stable(s1_char_ff) && $stable(s1_has_ff))
      else $error("blocked last character lost");

   // The parse state restarts after each string
   assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_last_ff |=> state_ff == ds2i_pkg::StateReset)
      else $error("parse state not cleared after string end");

   // Only a string end loads a result
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !(s1_fire && s1_last_ff) |=> !rsp_valid_ff)
      else $error("result appeared without a string end");

endmodule
